### hw/rtl/tdfe_pkg.sv
// ----------------------------------------------------------------------------
// tdfe_pkg
// Shared types, codes and sizes for the table driven state machine engine.
// ----------------------------------------------------------------------------
package tdfe_pkg;

  localparam int unsigned TRANSITION_ENTRIES = 16;
  localparam int unsigned ACTION_ENTRIES     = 16;

  localparam int unsigned STATE_W    = 8;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned TR_W       = 3 * STATE_W;

  localparam int unsigned TR_AW = (TRANSITION_ENTRIES > 1) ? $clog2(TRANSITION_ENTRIES) : 1;
  localparam int unsigned AC_AW = (ACTION_ENTRIES > 1) ? $clog2(ACTION_ENTRIES) : 1;
  localparam int unsigned TR_CW = $clog2(TRANSITION_ENTRIES + 1);
  localparam int unsigned AC_CW = $clog2(ACTION_ENTRIES + 1);
  localparam int unsigned TA_CW = (TR_CW > AC_CW) ? TR_CW : AC_CW;
  localparam int unsigned SCAN_CW = (TA_CW > CNT_W) ? TA_CW : CNT_W;

  localparam logic [STATE_W-1:0] NO_STATE = 8'hFF;

  typedef enum logic [1:0] {
    FUNC_LOAD_TR  = 2'd0,
    FUNC_LOAD_ACT = 2'd1,
    FUNC_EVENT    = 2'd2,
    FUNC_PERFORM  = 2'd3
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE    = 3'd0,
    KIND_EXIT    = 3'd1,
    KIND_ENTER   = 3'd2,
    KIND_RUNNING = 3'd3,
    KIND_FAILED  = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EVENT_COUNT   = 2'd0,
    CFG_ACTION_COUNT  = 2'd1,
    CFG_INITIAL_STATE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVENT_SCAN,
    ST_PERFORM_SCAN,
    ST_EMIT_ENTER
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0]   event_count;
    logic [CNT_W-1:0]   action_count;
    logic [STATE_W-1:0] initial_state;
    logic               init_load;
  } cfg_t;

  typedef struct packed {
    logic               accept;
    func_e              func;
    logic [STATE_W-1:0] event_id;
  } req_t;

  typedef struct packed {
    logic               strobe;
    kind_e              kind;
    logic [IDX_W-1:0]   index;
    logic [STATE_W-1:0] current_state;
    logic               last;
  } result_t;

endpackage

### hw/rtl/tdfe_ram.sv
// ----------------------------------------------------------------------------
// tdfe_ram
// Single port synchronous RAM, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module tdfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/tdfe_core.sv
// ----------------------------------------------------------------------------
// tdfe_core
// Sequencer: scans the transition and action memories and builds results.
// ----------------------------------------------------------------------------
module tdfe_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tdfe_pkg::cfg_t                cfg_i,
  input  tdfe_pkg::req_t                req_i,
  output logic                          busy_o,
  output logic [tdfe_pkg::TR_AW-1:0]    tr_rd_addr_o,
  input  logic [tdfe_pkg::TR_W-1:0]     tr_rdata_i,
  output logic [tdfe_pkg::AC_AW-1:0]    ac_rd_addr_o,
  input  logic [tdfe_pkg::STATE_W-1:0]  ac_rdata_i,
  output tdfe_pkg::result_t             result_o
);

  tdfe_pkg::state_e                   state_q, state_d;
  logic [tdfe_pkg::SCAN_CW-1:0]       scan_idx_q, scan_idx_d;
  logic [tdfe_pkg::AC_AW-1:0]         cmp_slot_q, cmp_slot_d;
  logic                               cmp_vld_q, cmp_vld_d;
  logic [tdfe_pkg::STATE_W-1:0]       event_q, event_d;
  logic [tdfe_pkg::STATE_W-1:0]       present_q, present_d;
  logic [tdfe_pkg::STATE_W-1:0]       pending_q, pending_d;
  logic                               xfer_q, xfer_d;
  logic                               found_cur_q, found_cur_d;
  logic                               found_nxt_q, found_nxt_d;
  logic [tdfe_pkg::AC_AW-1:0]         cur_slot_q, cur_slot_d;
  logic [tdfe_pkg::AC_AW-1:0]         nxt_slot_q, nxt_slot_d;
  tdfe_pkg::result_t                  res_q, res_d;

  logic [tdfe_pkg::SCAN_CW-1:0] tr_lim, ac_lim, scan_lim;
  logic [tdfe_pkg::STATE_W-1:0] tr_ev, tr_from, tr_to;
  logic scan_active, issue, scan_done, ev_hit, cur_hit, nxt_hit;

  // clamp the counts to the table sizes
  always_comb begin
    tr_lim = tdfe_pkg::SCAN_CW'(cfg_i.event_count);
    if (tdfe_pkg::SCAN_CW'(cfg_i.event_count) > tdfe_pkg::SCAN_CW'(tdfe_pkg::TRANSITION_ENTRIES)) begin
      tr_lim = tdfe_pkg::SCAN_CW'(tdfe_pkg::TRANSITION_ENTRIES);
    end
    ac_lim = tdfe_pkg::SCAN_CW'(cfg_i.action_count);
    if (tdfe_pkg::SCAN_CW'(cfg_i.action_count) > tdfe_pkg::SCAN_CW'(tdfe_pkg::ACTION_ENTRIES)) begin
      ac_lim = tdfe_pkg::SCAN_CW'(tdfe_pkg::ACTION_ENTRIES);
    end
  end

  assign scan_lim    = (state_q == tdfe_pkg::ST_EVENT_SCAN) ? tr_lim : ac_lim;
  assign scan_active = (state_q == tdfe_pkg::ST_EVENT_SCAN) ||
                       (state_q == tdfe_pkg::ST_PERFORM_SCAN);
  assign issue       = scan_active && (scan_idx_q < scan_lim);
  assign scan_done   = !issue && !cmp_vld_q;

  assign tr_rd_addr_o = scan_idx_q[tdfe_pkg::TR_AW-1:0];
  assign ac_rd_addr_o = scan_idx_q[tdfe_pkg::AC_AW-1:0];

  assign tr_ev   = tr_rdata_i[tdfe_pkg::TR_W-1 -: tdfe_pkg::STATE_W];
  assign tr_from = tr_rdata_i[tdfe_pkg::TR_W-tdfe_pkg::STATE_W-1 -: tdfe_pkg::STATE_W];
  assign tr_to   = tr_rdata_i[tdfe_pkg::STATE_W-1:0];

  assign ev_hit  = (state_q == tdfe_pkg::ST_EVENT_SCAN) && cmp_vld_q &&
                   (tr_ev == event_q) && (tr_from == present_q);
  assign cur_hit = (state_q == tdfe_pkg::ST_PERFORM_SCAN) && cmp_vld_q && !found_cur_q &&
                   (ac_rdata_i == present_q);
  assign nxt_hit = (state_q == tdfe_pkg::ST_PERFORM_SCAN) && cmp_vld_q && !found_nxt_q &&
                   (ac_rdata_i == pending_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tdfe_pkg::ST_IDLE: begin
        if (req_i.accept && req_i.func == tdfe_pkg::FUNC_EVENT) begin
          state_d = tdfe_pkg::ST_EVENT_SCAN;
        end else if (req_i.accept && req_i.func == tdfe_pkg::FUNC_PERFORM) begin
          state_d = tdfe_pkg::ST_PERFORM_SCAN;
        end
      end
      tdfe_pkg::ST_EVENT_SCAN: begin
        if (ev_hit || scan_done) begin
          state_d = tdfe_pkg::ST_IDLE;
        end
      end
      tdfe_pkg::ST_PERFORM_SCAN: begin
        if (scan_done) begin
          state_d = (xfer_q && found_cur_q && found_nxt_q) ? tdfe_pkg::ST_EMIT_ENTER
                                                           : tdfe_pkg::ST_IDLE;
        end
      end
      tdfe_pkg::ST_EMIT_ENTER: state_d = tdfe_pkg::ST_IDLE;
      default: state_d = tdfe_pkg::ST_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    scan_idx_d  = scan_idx_q;
    cmp_slot_d  = scan_idx_q[tdfe_pkg::AC_AW-1:0];
    cmp_vld_d   = issue && !ev_hit;
    event_d     = event_q;
    present_d   = present_q;
    pending_d   = pending_q;
    xfer_d      = xfer_q;
    found_cur_d = found_cur_q;
    found_nxt_d = found_nxt_q;
    cur_slot_d  = cur_slot_q;
    nxt_slot_d  = nxt_slot_q;
    res_d       = res_q;
    res_d.strobe = 1'b0;

    if (issue) begin
      scan_idx_d = scan_idx_q + 1'b1;
    end
    if (cur_hit) begin
      found_cur_d = 1'b1;
      cur_slot_d  = cmp_slot_q;
    end
    if (nxt_hit) begin
      found_nxt_d = 1'b1;
      nxt_slot_d  = cmp_slot_q;
    end
    if (ev_hit) begin
      pending_d = tr_to;
      xfer_d    = 1'b1;
    end

    unique case (state_q)
      tdfe_pkg::ST_IDLE: begin
        if (req_i.accept) begin
          scan_idx_d  = '0;
          event_d     = req_i.event_id;
          found_cur_d = 1'b0;
          found_nxt_d = 1'b0;
        end
      end
      tdfe_pkg::ST_EVENT_SCAN: ;
      tdfe_pkg::ST_PERFORM_SCAN: begin
        if (scan_done) begin
          xfer_d              = 1'b0;
          res_d.strobe        = 1'b1;
          res_d.current_state = present_q;
          res_d.last          = 1'b1;
          res_d.index         = '0;
          if (xfer_q) begin
            if (found_cur_q && found_nxt_q) begin
              res_d.kind  = tdfe_pkg::KIND_EXIT;
              res_d.index = tdfe_pkg::IDX_W'(cur_slot_q);
              res_d.last  = 1'b0;
            end else begin
              res_d.kind = tdfe_pkg::KIND_FAILED;
            end
          end else if (found_cur_q) begin
            res_d.kind  = tdfe_pkg::KIND_RUNNING;
            res_d.index = tdfe_pkg::IDX_W'(cur_slot_q);
          end else begin
            res_d.kind = tdfe_pkg::KIND_NONE;
          end
        end
      end
      tdfe_pkg::ST_EMIT_ENTER: begin
        present_d           = pending_q;
        pending_d           = tdfe_pkg::NO_STATE;
        res_d.strobe        = 1'b1;
        res_d.kind          = tdfe_pkg::KIND_ENTER;
        res_d.index         = tdfe_pkg::IDX_W'(nxt_slot_q);
        res_d.current_state = pending_q;
        res_d.last          = 1'b1;
      end
      default: ;
    endcase

    // initial state write loads the present state at once
    if (cfg_i.init_load) begin
      present_d = cfg_i.initial_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tdfe_pkg::ST_IDLE;
      cmp_vld_q <= 1'b0;
      present_q <= '0;
      pending_q <= '0;
      xfer_q    <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= cmp_vld_d;
      present_q <= present_d;
      pending_q <= pending_d;
      xfer_q    <= xfer_d;
      res_q     <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_idx_q  <= scan_idx_d;
    cmp_slot_q  <= cmp_slot_d;
    event_q     <= event_d;
    found_cur_q <= found_cur_d;
    found_nxt_q <= found_nxt_d;
    cur_slot_q  <= cur_slot_d;
    nxt_slot_q  <= nxt_slot_d;
  end

  assign busy_o   = (state_q != tdfe_pkg::ST_IDLE);
  assign result_o = res_q;

  a_enter_after_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.strobe && res_q.kind == tdfe_pkg::KIND_ENTER |->
      $past(res_q.strobe) && $past(res_q.kind) == tdfe_pkg::KIND_EXIT)
    else $error("enter result without preceding exit");

  a_exit_then_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.strobe && !res_q.last |=>
      res_q.strobe && res_q.last && res_q.kind == tdfe_pkg::KIND_ENTER)
    else $error("non-final result not followed by enter");

  a_idle_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tdfe_pkg::ST_IDLE |-> !cmp_vld_q)
    else $error("memory read still in flight while idle");

  a_enter_has_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tdfe_pkg::ST_EMIT_ENTER |-> found_cur_q && found_nxt_q && !xfer_q)
    else $error("transfer carried out without both action slots");

endmodule

### hw/rtl/table_driven_fsm_engine.sv
// ----------------------------------------------------------------------------
// table_driven_fsm_engine
// Programmable state machine: transition and action tables in RAM, event
// lookup and exit/enter/running/failed action reporting.
// ----------------------------------------------------------------------------
// channel   direction  handshake                     payload
// request   in         start_i & !busy_o             func_i, entry_index_i, event_id_i,
//                                                    from_state_i, to_state_i, action_state_i
// result    out        result_valid_o (one cycle)    action_kind_o, action_index_o,
//                                                    current_state_o, last_o
// config    in         cfg_valid_i & cfg_ready_o     cfg_index_i, cfg_data_i
//
// Load requests write their memory at the accepting edge.
// Event requests scan the transition memory and stop at the first match.
// Perform requests scan the action memory once for both states; a transfer with
// both action slots found adds a second (enter) result after the exit result.
// Reset clears control state; memory contents stay undefined until loaded.
// Results are shown for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module table_driven_fsm_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        func_i,
  input  logic [tdfe_pkg::IDX_W-1:0]        entry_index_i,
  input  logic [tdfe_pkg::STATE_W-1:0]      event_id_i,
  input  logic [tdfe_pkg::STATE_W-1:0]      from_state_i,
  input  logic [tdfe_pkg::STATE_W-1:0]      to_state_i,
  input  logic [tdfe_pkg::STATE_W-1:0]      action_state_i,
  output logic                              result_valid_o,
  output logic [tdfe_pkg::KIND_W-1:0]       action_kind_o,
  output logic [tdfe_pkg::IDX_W-1:0]        action_index_o,
  output logic [tdfe_pkg::STATE_W-1:0]      current_state_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tdfe_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tdfe_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic [tdfe_pkg::CNT_W-1:0]   event_count_q, action_count_q;
  logic                         cfg_we, init_load;

  tdfe_pkg::cfg_t    cfg;
  tdfe_pkg::req_t    req;
  tdfe_pkg::result_t result;
  tdfe_pkg::func_e   func;

  logic                         accept, tr_we, ac_we;
  logic [tdfe_pkg::TR_AW-1:0]   tr_addr, tr_rd_addr;
  logic [tdfe_pkg::AC_AW-1:0]   ac_addr, ac_rd_addr;
  logic [tdfe_pkg::TR_W-1:0]    tr_rdata;
  logic [tdfe_pkg::STATE_W-1:0] ac_rdata;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    init_load = 1'b0;
    unique case (tdfe_pkg::cfg_idx_e'(cfg_index_i))
      tdfe_pkg::CFG_INITIAL_STATE: init_load = cfg_we;
      default:                     init_load = 1'b0;
    endcase
  end

  // the initial state only takes effect through the present state load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_count_q   <= '0;
      action_count_q  <= '0;
    end else if (cfg_we) begin
      unique case (tdfe_pkg::cfg_idx_e'(cfg_index_i))
        tdfe_pkg::CFG_EVENT_COUNT:   event_count_q   <= cfg_data_i[tdfe_pkg::CNT_W-1:0];
        tdfe_pkg::CFG_ACTION_COUNT:  action_count_q  <= cfg_data_i[tdfe_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{event_count:   event_count_q,
                 action_count:  action_count_q,
                 initial_state: cfg_data_i,
                 init_load:     init_load};

  // request decode; loads go straight to memory
  assign accept = start_i && !busy_o;
  assign func   = tdfe_pkg::func_e'(func_i);
  assign req    = '{accept: accept, func: func, event_id: event_id_i};

  assign tr_we = accept && (func == tdfe_pkg::FUNC_LOAD_TR) &&
                 (32'(entry_index_i) < tdfe_pkg::TRANSITION_ENTRIES);
  assign ac_we = accept && (func == tdfe_pkg::FUNC_LOAD_ACT) &&
                 (32'(entry_index_i) < tdfe_pkg::ACTION_ENTRIES);

  assign tr_addr = tr_we ? tdfe_pkg::TR_AW'(entry_index_i) : tr_rd_addr;
  assign ac_addr = ac_we ? tdfe_pkg::AC_AW'(entry_index_i) : ac_rd_addr;

  tdfe_ram #(
    .WIDTH (tdfe_pkg::TR_W),
    .DEPTH (tdfe_pkg::TRANSITION_ENTRIES)
  ) u_tr_ram (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .addr_i  (tr_addr),
    .wdata_i ({event_id_i, from_state_i, to_state_i}),
    .rdata_o (tr_rdata)
  );

  tdfe_ram #(
    .WIDTH (tdfe_pkg::STATE_W),
    .DEPTH (tdfe_pkg::ACTION_ENTRIES)
  ) u_ac_ram (
    .clk_i   (clk_i),
    .we_i    (ac_we),
    .addr_i  (ac_addr),
    .wdata_i (action_state_i),
    .rdata_o (ac_rdata)
  );

  tdfe_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .req_i        (req),
    .busy_o       (busy_o),
    .tr_rd_addr_o (tr_rd_addr),
    .tr_rdata_i   (tr_rdata),
    .ac_rd_addr_o (ac_rd_addr),
    .ac_rdata_i   (ac_rdata),
    .result_o     (result)
  );

  assign result_valid_o  = result.strobe;
  assign action_kind_o   = result.kind;
  assign action_index_o  = result.index;
  assign current_state_o = result.current_state;
  assign last_o          = result.last;

endmodule
